FILE: rtl/pws_pkg.sv
// Package for the pulse width statistics block: shared types and constants.
// Used by pws_divider, pws_stats and pulse_width_statistics. No dependencies.
`timescale 1ns / 1ps
package pws_pkg;

   localparam int unsigned DATA_W     = 32;
   localparam int unsigned RATE_W     = 20;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned DIV_CNT_W  = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_HIGH = 2'd1;

   localparam logic [DATA_W-1:0] WINDOW_LOW_RESET  = 32'd50;
   localparam logic [DATA_W-1:0] WINDOW_HIGH_RESET = 32'd100000;
   localparam logic [DATA_W-1:0] BITRATE_NUMERATOR = 32'd1000000;

   localparam logic MODE_PULSE = 1'b0;
   localparam logic MODE_CLEAR = 1'b1;

   typedef struct packed {
      logic [DATA_W-1:0] edge_total;
      logic [DATA_W-1:0] shortest;
      logic [DATA_W-1:0] longest;
      logic [DATA_W-1:0] duration_sum;
      logic [DATA_W-1:0] pulse_total;
   } stats_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [DATA_W-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: rtl/pws_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle, 32 steps per division.
// Depends on pws_pkg for widths and the request and response structs.
`timescale 1ns / 1ps
module pws_divider
   import pws_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [DATA_W-1:0]    dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [DATA_W:0]   partial;
   logic [DATA_W+1:0] diff;
   logic              q_bit;

   assign partial = {rem_ff, quo_ff[DATA_W-1]};
   assign diff    = {1'b0, partial} - {2'b00, dvs_ff};
   assign q_bit   = ~diff[DATA_W+1];

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start && !busy_ff) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         cnt_in  = '1;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = q_bit ? diff[DATA_W-1:0] : partial[DATA_W-1:0];
         quo_in = {quo_ff[DATA_W-2:0], q_bit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

FILE: rtl/pws_stats.sv
// Statistics registers: edge count, window-qualified minimum, maximum, sum and count.
// Depends on pws_pkg for stats_type and the mode codes.
`timescale 1ns / 1ps
module pws_stats
   import pws_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic              mode,
   input  logic [DATA_W-1:0] pulse_length,
   input  logic [DATA_W-1:0] window_low,
   input  logic [DATA_W-1:0] window_high,
   output stats_type         stats
);

   stats_type stats_ff, stats_in;
   logic      qualifies;

   assign qualifies = (pulse_length >= window_low) && (pulse_length <= window_high);

   always_comb begin
      stats_in = stats_ff;
      if (take) begin
         unique case (mode)
            MODE_CLEAR: begin
               stats_in = '0;
            end
            MODE_PULSE: begin
               stats_in.edge_total = stats_ff.edge_total + 1'b1;
               if (qualifies) begin
                  // A shortest value of zero means no qualifying pulse yet.
                  if (stats_ff.shortest == '0 || pulse_length < stats_ff.shortest) begin
                     stats_in.shortest = pulse_length;
                  end
                  if (pulse_length > stats_ff.longest) begin
                     stats_in.longest = pulse_length;
                  end
                  stats_in.duration_sum = stats_ff.duration_sum + pulse_length;
                  stats_in.pulse_total  = stats_ff.pulse_total + 1'b1;
               end
            end
            default: begin
               stats_in = stats_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stats_ff <= '0;
      end else begin
         stats_ff <= stats_in;
      end
   end

   assign stats = stats_ff;

endmodule

FILE: rtl/pulse_width_statistics.sv
// Top level of the pulse width statistics block: sequencer, window registers, result register.
// Depends on pws_pkg, pws_stats and pws_divider.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | req_valid/ready, mode, pulse_length     | in
//  rsp     | rsp_valid/ready, edge_total .. bitrate  | out
//  csr     | csr_valid/ready, index, wdata           | in
//
// Each accepted item runs two 32-step passes through the one shared radix-2 divider (mean,
// then bitrate), in the sequencer states mean start, mean wait, rate start and rate wait; the
// output state then loads the result register once any earlier result has been taken.
// The block accepts one item at a time; req_ready is high only while the sequencer idles.
// A finished result waits in the output register while the next item is accepted.
// Synchronous active-high reset clears statistics and restores the window defaults.
`timescale 1ns / 1ps
module pulse_width_statistics
   import pws_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_mode,
   input  logic [DATA_W-1:0]    req_pulse_length,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DATA_W-1:0]    rsp_edge_total_out,
   output logic [DATA_W-1:0]    rsp_shortest_out,
   output logic [DATA_W-1:0]    rsp_longest_out,
   output logic [DATA_W-1:0]    rsp_mean_out,
   output logic [RATE_W-1:0]    rsp_bitrate_out,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   localparam logic [2:0] S_IDLE       = 3'd0;
   localparam logic [2:0] S_MEAN_START = 3'd1;
   localparam logic [2:0] S_MEAN_WAIT  = 3'd2;
   localparam logic [2:0] S_RATE_START = 3'd3;
   localparam logic [2:0] S_RATE_WAIT  = 3'd4;
   localparam logic [2:0] S_OUTPUT     = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [DATA_W-1:0] window_low_ff, window_low_in;
   logic [DATA_W-1:0] window_high_ff, window_high_in;
   logic [DATA_W-1:0] mean_ff, mean_in;
   logic [RATE_W-1:0] rate_ff, rate_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] out_edge_ff, out_edge_in;
   logic [DATA_W-1:0] out_short_ff, out_short_in;
   logic [DATA_W-1:0] out_long_ff, out_long_in;
   logic [DATA_W-1:0] out_mean_ff, out_mean_in;
   logic [RATE_W-1:0] out_rate_ff, out_rate_in;

   logic        req_take;
   stats_type   stats;
   div_req_type div_req;
   div_rsp_type div_rsp;

   assign req_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   pws_stats u_stats (
      .clock        (clock),
      .reset        (reset),
      .take         (req_take),
      .mode         (req_mode),
      .pulse_length (req_pulse_length),
      .window_low   (window_low_ff),
      .window_high  (window_high_ff),
      .stats        (stats)
   );

   pws_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      div_req.start    = (state_ff == S_MEAN_START) || (state_ff == S_RATE_START);
      div_req.dividend = (state_ff == S_RATE_START) ? BITRATE_NUMERATOR : stats.duration_sum;
      div_req.divisor  = (state_ff == S_RATE_START) ? stats.shortest : stats.pulse_total;
   end

   always_comb begin
      window_low_in  = window_low_ff;
      window_high_in = window_high_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_WINDOW_LOW) begin
            window_low_in = csr_wdata;
         end
         if (csr_index == CSR_WINDOW_HIGH) begin
            window_high_in = csr_wdata;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      mean_in      = mean_ff;
      rate_in      = rate_ff;
      rsp_valid_in = rsp_valid_ff;
      out_edge_in  = out_edge_ff;
      out_short_in = out_short_ff;
      out_long_in  = out_long_ff;
      out_mean_in  = out_mean_ff;
      out_rate_in  = out_rate_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_MEAN_START;
            end
         end
         S_MEAN_START: begin
            state_in = S_MEAN_WAIT;
         end
         S_MEAN_WAIT: begin
            if (div_rsp.done) begin
               // Divisor zero yields all ones from the divider, so it is masked here.
               mean_in  = (stats.pulse_total == '0) ? '0 : div_rsp.quotient;
               state_in = S_RATE_START;
            end
         end
         S_RATE_START: begin
            state_in = S_RATE_WAIT;
         end
         S_RATE_WAIT: begin
            if (div_rsp.done) begin
               rate_in  = (stats.shortest == '0) ? '0 : div_rsp.quotient[RATE_W-1:0];
               state_in = S_OUTPUT;
            end
         end
         S_OUTPUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               out_edge_in  = stats.edge_total;
               out_short_in = stats.shortest;
               out_long_in  = stats.longest;
               out_mean_in  = mean_ff;
               out_rate_in  = rate_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         window_low_ff  <= WINDOW_LOW_RESET;
         window_high_ff <= WINDOW_HIGH_RESET;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         window_low_ff  <= window_low_in;
         window_high_ff <= window_high_in;
      end
      mean_ff      <= mean_in;
      rate_ff      <= rate_in;
      out_edge_ff  <= out_edge_in;
      out_short_ff <= out_short_in;
      out_long_ff  <= out_long_in;
      out_mean_ff  <= out_mean_in;
      out_rate_ff  <= out_rate_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_edge_total_out = out_edge_ff;
   assign rsp_shortest_out   = out_short_ff;
   assign rsp_longest_out    = out_long_ff;
   assign rsp_mean_out       = out_mean_ff;
   assign rsp_bitrate_out    = out_rate_ff;

`ifndef SYNTHESIS
   // No item may enter while a division is still running.
   a_no_take_while_dividing: assert property (@(posedge clock) disable iff (reset)
      req_take |-> !div_rsp.busy)
      else $error("item accepted while divider busy");

   // A reported bitrate is zero whenever no shortest pulse is known.
   a_rate_zero_without_min: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_shortest_out == '0) |-> (rsp_bitrate_out == '0))
      else $error("nonzero bitrate with zero shortest");

   // Once a nonzero shortest pulse exists it never exceeds the longest one.
   a_min_not_above_max: assert property (@(posedge clock) disable iff (reset)
      (stats.shortest != '0) |-> (stats.shortest <= stats.longest))
      else $error("shortest above longest");

   // The divider only reports completion while the sequencer is waiting for it.
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_MEAN_WAIT || state_ff == S_RATE_WAIT))
      else $error("divider completion outside a wait state");
`endif

endmodule

FILE: sim/pws_checker.sv
// Checker for the pulse width statistics block: keeps its own copy of the window
// registers and statistics, predicts each result and compares it field by field.
// Depends on pws_pkg for widths, register indexes and mode codes.
`timescale 1ns / 1ps
module pws_checker
   import pws_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic                 req_mode,
   input  logic [DATA_W-1:0]    req_pulse_length,

   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [DATA_W-1:0]    rsp_edge_total_out,
   input  logic [DATA_W-1:0]    rsp_shortest_out,
   input  logic [DATA_W-1:0]    rsp_longest_out,
   input  logic [DATA_W-1:0]    rsp_mean_out,
   input  logic [RATE_W-1:0]    rsp_bitrate_out,

   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata,

   output int unsigned          error_count,
   output int unsigned          pending_count,
   output int unsigned          report_count
);

   typedef struct packed {
      logic [DATA_W-1:0] edge_total;
      logic [DATA_W-1:0] shortest;
      logic [DATA_W-1:0] longest;
      logic [DATA_W-1:0] mean;
      logic [RATE_W-1:0] bitrate;
   } pulse_report_t;

   logic [DATA_W-1:0] win_low  = WINDOW_LOW_RESET;
   logic [DATA_W-1:0] win_high = WINDOW_HIGH_RESET;
   stats_type         tally    = '0;
   pulse_report_t     report_q[$];
   int unsigned       errors   = 0;
   int unsigned       checked  = 0;

   function automatic stats_type tally_item(stats_type s, logic [DATA_W-1:0] lo,
                                            logic [DATA_W-1:0] hi, logic mode,
                                            logic [DATA_W-1:0] len);
      stats_type n;
      n = s;
      if (mode == MODE_CLEAR) begin
         n = '0;
      end else begin
         n.edge_total = s.edge_total + 1;
         if (len >= lo && len <= hi) begin
            // A shortest of zero means no qualifying pulse yet, so it is always replaced.
            if (s.shortest == '0 || len < s.shortest) begin
               n.shortest = len;
            end
            if (len > s.longest) begin
               n.longest = len;
            end
            n.duration_sum = s.duration_sum + len;
            n.pulse_total  = s.pulse_total + 1;
         end
      end
      return n;
   endfunction

   function automatic pulse_report_t report_of(stats_type s);
      pulse_report_t     r;
      logic [DATA_W-1:0] rate;
      r.edge_total = s.edge_total;
      r.shortest   = s.shortest;
      r.longest    = s.longest;
      r.mean       = (s.pulse_total != '0) ? s.duration_sum / s.pulse_total : '0;
      rate         = (s.shortest != '0) ? BITRATE_NUMERATOR / s.shortest : '0;
      r.bitrate    = rate[RATE_W-1:0];
      return r;
   endfunction

   task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      pulse_report_t want;
      if (reset) begin
         win_low  = WINDOW_LOW_RESET;
         win_high = WINDOW_HIGH_RESET;
         tally    = '0;
         report_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (report_q.size() == 0) begin
               errors++;
               $display("%0t: result item arrived with no expectation waiting", $time);
            end else begin
               want = report_q.pop_front();
               checked++;
               check_field("edge_total", want.edge_total, rsp_edge_total_out);
               check_field("shortest", want.shortest, rsp_shortest_out);
               check_field("longest", want.longest, rsp_longest_out);
               check_field("mean", want.mean, rsp_mean_out);
               check_field("bitrate", DATA_W'(want.bitrate), DATA_W'(rsp_bitrate_out));
            end
         end
         // An item accepted at the same edge as a register write still sees the old window.
         if (req_valid && req_ready) begin
            tally = tally_item(tally, win_low, win_high, req_mode, req_pulse_length);
            report_q.push_back(report_of(tally));
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WINDOW_LOW: begin
                  win_low = csr_wdata;
               end
               CSR_WINDOW_HIGH: begin
                  win_high = csr_wdata;
               end
               default: begin
               end
            endcase
         end
      end
      error_count   <= errors;
      pending_count <= report_q.size();
      report_count  <= checked;
   end

endmodule

FILE: sim/testbench.sv
// Top of the pulse width statistics testbench: clock, reset, stimulus and verdict.
// Depends on pws_pkg, the pulse_width_statistics block and pws_checker.
`timescale 1ns / 1ps
module testbench
   import pws_pkg::*;
();

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int unsigned SEGMENTS_PER_PHASE = 6;
   localparam int unsigned ITEMS_PER_SEGMENT  = 110;
   localparam int unsigned LONG_STALL_CYCLES  = 400;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_mode;
   logic [DATA_W-1:0]    req_pulse_length;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [DATA_W-1:0]    rsp_edge_total_out;
   logic [DATA_W-1:0]    rsp_shortest_out;
   logic [DATA_W-1:0]    rsp_longest_out;
   logic [DATA_W-1:0]    rsp_mean_out;
   logic [RATE_W-1:0]    rsp_bitrate_out;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0]    csr_wdata;

   int unsigned error_count;
   int unsigned pending_count;
   int unsigned report_count;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned stall_ask     = 0;
   int unsigned items_sent    = 0;
   int unsigned clears_sent   = 0;
   int unsigned settings_used = 0;
   logic [DATA_W-1:0] cur_low  = WINDOW_LOW_RESET;
   logic [DATA_W-1:0] cur_high = WINDOW_HIGH_RESET;

   pulse_width_statistics dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_mode(req_mode), .req_pulse_length(req_pulse_length),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_edge_total_out(rsp_edge_total_out), .rsp_shortest_out(rsp_shortest_out),
      .rsp_longest_out(rsp_longest_out), .rsp_mean_out(rsp_mean_out),
      .rsp_bitrate_out(rsp_bitrate_out),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   pws_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_mode(req_mode), .req_pulse_length(req_pulse_length),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_edge_total_out(rsp_edge_total_out), .rsp_shortest_out(rsp_shortest_out),
      .rsp_longest_out(rsp_longest_out), .rsp_mean_out(rsp_mean_out),
      .rsp_bitrate_out(rsp_bitrate_out),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .error_count(error_count), .pending_count(pending_count),
      .report_count(report_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #15_000_000;
      $display("testbench failed");
      $finish;
   end

   // Receiver: random back-pressure, plus a long hold-off whenever the stimulus asks for one.
   initial begin : receiver
      int unsigned stall_seen;
      int unsigned stall_left;
      stall_seen = 0;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_ask != stall_seen) begin
            stall_seen = stall_ask;
            stall_left = LONG_STALL_CYCLES;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Valid stays high across back-to-back items; it is lowered only for an idle gap or by drain.
   task automatic send_item(input logic mode, input logic [DATA_W-1:0] len);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_pulse_length <= len;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (mode == MODE_CLEAR) begin
         clears_sent++;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_windows(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
      write_reg(CSR_WINDOW_LOW, lo);
      write_reg(CSR_WINDOW_HIGH, hi);
      csr_valid <= 1'b0;
      cur_low  = lo;
      cur_high = hi;
      settings_used++;
   endtask

   task automatic choose_windows(input int unsigned profile);
      logic [DATA_W-1:0] lo;
      logic [DATA_W-1:0] hi;
      case (profile)
         0: begin
            lo = WINDOW_LOW_RESET;
            hi = WINDOW_HIGH_RESET;
         end
         1: begin
            lo = '0;
            hi = '1;
         end
         2: begin
            lo = $urandom_range(5000);
            hi = lo + $urandom_range(200000);
         end
         3: begin
            // Empty window: low above high.
            lo = $urandom_range(100000, 1);
            hi = lo - 1 - $urandom_range(lo - 1);
         end
         4: begin
            lo = '0;
            hi = '0;
         end
         5: begin
            lo = $urandom_range(3000, 1);
            hi = lo;
         end
         6: begin
            lo = $urandom;
            hi = $urandom;
         end
         default: begin
            lo = '1;
            hi = '1;
         end
      endcase
      set_windows(lo, hi);
   endtask

   function automatic logic [DATA_W-1:0] pick_length();
      int unsigned       sel;
      longint unsigned   span;
      logic [DATA_W-1:0] len;
      sel = $urandom_range(99);
      if (sel < 45 && cur_low <= cur_high) begin
         span = longint'(cur_high) - longint'(cur_low) + 1;
         len  = cur_low + DATA_W'({$urandom, $urandom} % span);
      end else if (sel < 65) begin
         case ($urandom_range(3))
            0: len = cur_low - 1;
            1: len = cur_low;
            2: len = cur_high;
            default: len = cur_high + 1;
         endcase
      end else if (sel < 85) begin
         len = $urandom_range(2000);
      end else begin
         len = $urandom;
      end
      return len;
   endfunction

   initial begin : stimulus
      logic mode;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_mode         = MODE_PULSE;
      req_pulse_length = '0;
      csr_valid        = 1'b0;
      csr_index        = CSR_WINDOW_LOW;
      csr_wdata        = '0;
      send_idle_pct    = 9;
      recv_idle_pct    = 82;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset windows: edges of the window, outside on both sides, all ones, one inside, then a clear.
      send_item(MODE_PULSE, 32'd0);
      send_item(MODE_PULSE, 32'd50);
      send_item(MODE_PULSE, 32'd49);
      send_item(MODE_PULSE, 32'd100000);
      send_item(MODE_PULSE, 32'd100001);
      send_item(MODE_PULSE, 32'hFFFF_FFFF);
      send_item(MODE_PULSE, 32'd1234);
      send_item(MODE_CLEAR, 32'hFFFF_FFFF);
      drain();
      // Full window: a zero-length pulse leaves shortest at zero, big pulses wrap the sum.
      set_windows('0, '1);
      send_item(MODE_PULSE, 32'd0);
      send_item(MODE_PULSE, 32'd1);
      send_item(MODE_PULSE, 32'hFFFF_FFFF);
      send_item(MODE_PULSE, 32'hFFFF_FFFF);
      send_item(MODE_PULSE, 32'h8000_0000);
      send_item(MODE_PULSE, 32'd0);
      send_item(MODE_CLEAR, 32'd0);
      drain();
      // Empty window: only the edge count moves.
      set_windows(32'd200, 32'd100);
      send_item(MODE_PULSE, 32'd150);
      send_item(MODE_PULSE, 32'd200);
      send_item(MODE_PULSE, 32'd100);
      drain();
      // A write to an unused index must leave both windows alone.
      write_reg(CSR_UNUSED, '0);
      csr_valid <= 1'b0;
      send_item(MODE_PULSE, 32'd150);
      drain();
      set_windows(32'd777, 32'd777);
      send_item(MODE_PULSE, 32'd777);
      send_item(MODE_PULSE, 32'd776);
      send_item(MODE_PULSE, 32'd778);
      send_item(MODE_PULSE, 32'd777);

      for (int phase = 0; phase < 3; phase++) begin
         drain();
         case (phase)
            0: begin
               send_idle_pct = 9;
               recv_idle_pct <= 82;
            end
            1: begin
               send_idle_pct = 82;
               recv_idle_pct <= 9;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct <= 0;
            end
         endcase
         for (int seg = 0; seg < SEGMENTS_PER_PHASE; seg++) begin
            drain();
            choose_windows((phase * SEGMENTS_PER_PHASE + seg) % 8);
            // Hold the receiver off while items keep coming, so the block fills and stalls.
            if (seg == 1) begin
               stall_ask <= stall_ask + 1;
            end
            for (int k = 0; k < ITEMS_PER_SEGMENT; k++) begin
               mode = ($urandom_range(99) < 5) ? MODE_CLEAR : MODE_PULSE;
               send_item(mode, (mode == MODE_CLEAR) ? DATA_W'($urandom) : pick_length());
            end
         end
      end

      drain();
      repeat (100) @(posedge clock);
      $display("Sent %0d items (%0d clears) under %0d window settings; %0d results checked.",
               items_sent, clears_sent, settings_used, report_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/pws_pkg.sv
rtl/pws_divider.sv
rtl/pws_stats.sv
rtl/pulse_width_statistics.sv
sim/pws_checker.sv
sim/testbench.sv
